// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on aclk, held off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define GEE_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define GEE_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/gee_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gee_pkg
// types and constants of the grounded extension engine
// ----------------------------------------------------------------------------
package gee_pkg;

    localparam int FIELD_W = 6;
    localparam int CFG_W   = 6;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_RUN   = 2'd2,
        OP_NOP   = 2'd3
    } gee_op_t;

    localparam logic [1:0] CFG_ARG_COUNT  = 2'd0;
    localparam logic [1:0] CFG_STOP_CONT  = 2'd1;
    localparam logic [1:0] CFG_STOP_ATT   = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [FIELD_W-1:0] attacker;
        logic [FIELD_W-1:0] victim;
        logic [FIELD_W-1:0] query;
    } gee_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] member;
        logic               is_last;
        logic               contained;
        logic               attacked;
    } gee_out_t;

endpackage

// ===== hdl/gee_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gee_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module gee_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/grounded_extension_engine.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// grounded_extension_engine
// attack graph store and grounded extension solver with a queue walker
// ----------------------------------------------------------------------------
// Usage: items arrive on s_valid/s_ready/s_data. opcode clear empties the
// graph, add stores one attack edge, run computes the grounded extension
// (the members queued so far when an early stop fires) and streams it on
// m_valid/m_ready/m_data, one transfer per member in queue order, is_last on
// the final one (a single member 0 when the extension is empty). contained/
// attacked report the query on the last transfer. s_ready is high only while
// no item is in work, so one item is handled at a time. A run counts
// attackers with one matrix row read per argument, seeds the queue with the
// unattacked arguments, then per popped argument reads its row and walks its
// active victims, queuing arguments left unattacked, until the queue is
// empty, then emits the members; the single matrix ram read port serializes
// these reads. Configuration goes through cfg_wr_en/cfg_index/cfg_wdata,
// written by the user only while the block is idle, a rule left unchecked.
// Reset clears the graph (row valid bits), the configuration and the
// sequencer. When the receiver stalls the current result is held and the
// walk waits; no result is dropped.
// ----------------------------------------------------------------------------
module grounded_extension_engine import gee_pkg::*; #(
    parameter int MAX_ARGS = 63
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  gee_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output gee_out_t         m_data
);

    localparam int NARG = MAX_ARGS + 1;
    localparam int IW   = $clog2(NARG);
    localparam int QW   = $clog2(NARG + 1);
    localparam int CW   = $clog2(NARG + 1);

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_EDGE_RD  = 15'b000000000000010,
        S_EDGE_WR  = 15'b000000000000100,
        S_CNT_RD   = 15'b000000000001000,
        S_CNT_ACC  = 15'b000000000010000,
        S_SEED     = 15'b000000000100000,
        S_ENQ      = 15'b000000001000000,
        S_POP_RD   = 15'b000000010000000,
        S_POP_WAIT = 15'b000000100000000,
        S_ROW_WAIT = 15'b000001000000000,
        S_VIC_NEXT = 15'b000010000000000,
        S_SEC_WAIT = 15'b000100000000000,
        S_EMIT_RD  = 15'b001000000000000,
        S_EMIT_LD  = 15'b010000000000000,
        S_EMIT_OUT = 15'b100000000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [FIELD_W-1:0]  arg_count_reg, arg_count_next;
    logic                stop_c_reg, stop_c_next;
    logic                stop_a_reg, stop_a_next;
    logic [NARG-1:0]     row_valid_reg, row_valid_next;
    logic                rd_valid_reg;
    logic [NARG-1:0]     active_reg, active_next;
    logic [CW-1:0]       cnt_reg [NARG];
    logic [CW-1:0]       cnt_next [NARG];
    logic [NARG-1:0]     pend_reg, pend_next;
    logic [NARG-1:0]     vic_reg, vic_next;
    logic [NARG-1:0]     row_ua_reg, row_ua_next;
    logic [IW-1:0]       ua_reg, ua_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [IW-1:0]       bit_reg, bit_next;
    logic [FIELD_W-1:0]  query_reg, query_next;
    logic [QW-1:0]       head_reg, head_next;
    logic [QW-1:0]       tail_reg, tail_next;
    logic [QW-1:0]       k_reg, k_next;
    logic                contained_reg, contained_next;
    logic                attacked_reg, attacked_next;
    logic                enq_pop_reg, enq_pop_next;
    gee_out_t            out_reg, out_next;

    logic                mx_we;
    logic [IW-1:0]       mx_waddr, mx_raddr;
    logic [NARG-1:0]     mx_wdata, mx_rdata, mx_row;
    logic                q_we;
    logic [IW-1:0]       q_waddr, q_raddr;
    logic [FIELD_W-1:0]  q_wdata, q_rdata;

    logic [FIELD_W-1:0]  n_arg;
    logic [NARG-1:0]     range_mask;
    logic [NARG-1:0]     second;
    logic [IW-1:0]       low_idx;
    logic                hit;

    function automatic logic [IW-1:0] lowest(input logic [NARG-1:0] vec);
        logic [IW-1:0] r;
        r = '0;
        for (int i = NARG - 1; i >= 0; i--) begin
            if (vec[i]) begin
                r = IW'(i);
            end
        end
        return r;
    endfunction

    gee_ram #(.WIDTH(NARG), .DEPTH(NARG)) u_matrix (
        .aclk  (aclk),
        .we    (mx_we),
        .waddr (mx_waddr),
        .wdata (mx_wdata),
        .raddr (mx_raddr),
        .rdata (mx_rdata)
    );

    gee_ram #(.WIDTH(FIELD_W), .DEPTH(NARG)) u_queue (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    // rows never written since the last clear read as empty
    assign mx_row  = rd_valid_reg ? mx_rdata : '0;
    assign n_arg   = (arg_count_reg > FIELD_W'(MAX_ARGS)) ? FIELD_W'(MAX_ARGS) : arg_count_reg;
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_EMIT_OUT);
    assign m_data  = out_reg;
    assign second  = mx_row & active_reg;

    always_comb begin
        for (int i = 0; i < NARG; i++) begin
            range_mask[i] = (i != 0) && (FIELD_W'(i) <= n_arg);
        end
    end

    always_comb begin
        state_next     = state_reg;
        arg_count_next = arg_count_reg;
        stop_c_next    = stop_c_reg;
        stop_a_next    = stop_a_reg;
        row_valid_next = row_valid_reg;
        active_next    = active_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        vic_next       = vic_reg;
        row_ua_next    = row_ua_reg;
        ua_next        = ua_reg;
        idx_next       = idx_reg;
        bit_next       = bit_reg;
        query_next     = query_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        k_next         = k_reg;
        contained_next = contained_reg;
        attacked_next  = attacked_reg;
        enq_pop_next   = enq_pop_reg;
        out_next       = out_reg;
        mx_we          = 1'b0;
        mx_waddr       = idx_reg;
        mx_wdata       = mx_row | (NARG'(1) << bit_reg);
        mx_raddr       = idx_reg;
        q_we           = 1'b0;
        q_waddr        = tail_reg[IW-1:0];
        q_wdata        = '0;
        q_raddr        = head_reg[IW-1:0];
        low_idx        = '0;
        hit            = 1'b0;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ARG_COUNT: arg_count_next = cfg_wdata;
                CFG_STOP_CONT: stop_c_next    = cfg_wdata[0];
                CFG_STOP_ATT:  stop_a_next    = cfg_wdata[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (s_data.opcode)
                        OP_CLEAR: row_valid_next = '0;
                        OP_ADD: begin
                            if (s_data.attacker <= FIELD_W'(MAX_ARGS) &&
                                s_data.victim <= FIELD_W'(MAX_ARGS)) begin
                                idx_next   = IW'(s_data.attacker);
                                bit_next   = IW'(s_data.victim);
                                state_next = S_EDGE_RD;
                            end
                        end
                        OP_RUN: begin
                            active_next    = range_mask;
                            head_next      = '0;
                            tail_next      = '0;
                            contained_next = 1'b0;
                            attacked_next  = 1'b0;
                            query_next     = s_data.query;
                            for (int i = 0; i < NARG; i++) begin
                                cnt_next[i] = '0;
                            end
                            idx_next   = IW'(1);
                            state_next = (n_arg == '0) ? S_SEED : S_CNT_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_EDGE_RD: begin
                mx_raddr   = idx_reg;
                state_next = S_EDGE_WR;
            end
            S_EDGE_WR: begin
                mx_we                   = 1'b1;
                row_valid_next[idx_reg] = 1'b1;
                state_next              = S_IDLE;
            end
            S_CNT_RD: begin
                mx_raddr   = idx_reg;
                state_next = S_CNT_ACC;
            end
            S_CNT_ACC: begin
                // one matrix row adds its bits into every column counter
                for (int i = 0; i < NARG; i++) begin
                    cnt_next[i] = cnt_reg[i] + CW'(mx_row[i] & range_mask[i]);
                end
                if (idx_reg == IW'(n_arg)) begin
                    state_next = S_SEED;
                end else begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_CNT_RD;
                end
            end
            S_SEED: begin
                for (int i = 0; i < NARG; i++) begin
                    pend_next[i] = range_mask[i] && (cnt_reg[i] == '0);
                end
                enq_pop_next = 1'b1;
                state_next   = S_ENQ;
            end
            S_ENQ: begin
                // push pending arguments in ascending order
                if (pend_reg != '0) begin
                    low_idx            = lowest(pend_reg);
                    q_we               = 1'b1;
                    q_waddr            = tail_reg[IW-1:0];
                    q_wdata            = FIELD_W'(low_idx);
                    tail_next          = tail_reg + QW'(1);
                    pend_next[low_idx] = 1'b0;
                end else begin
                    state_next = enq_pop_reg ? S_POP_RD : S_VIC_NEXT;
                end
            end
            S_POP_RD: begin
                if (head_reg == tail_reg) begin
                    k_next     = '0;
                    state_next = S_EMIT_RD;
                end else begin
                    q_raddr    = head_reg[IW-1:0];
                    state_next = S_POP_WAIT;
                end
            end
            S_POP_WAIT: begin
                ua_next   = IW'(q_rdata);
                head_next = head_reg + QW'(1);
                hit       = (query_reg != '0) && (query_reg == q_rdata);
                if (hit) begin
                    contained_next = 1'b1;
                end
                if (hit && stop_c_reg) begin
                    k_next     = '0;
                    state_next = S_EMIT_RD;
                end else begin
                    mx_raddr   = IW'(q_rdata);
                    state_next = S_ROW_WAIT;
                end
            end
            S_ROW_WAIT: begin
                row_ua_next = mx_row;
                vic_next    = mx_row & active_reg;
                state_next  = S_VIC_NEXT;
            end
            S_VIC_NEXT: begin
                if (vic_reg == '0) begin
                    active_next = active_reg & ~(row_ua_reg | (NARG'(1) << ua_reg));
                    state_next  = S_POP_RD;
                end else begin
                    low_idx           = lowest(vic_reg);
                    vic_next[low_idx] = 1'b0;
                    hit = (query_reg != '0) && (query_reg == FIELD_W'(low_idx));
                    if (hit) begin
                        attacked_next = 1'b1;
                    end
                    if (hit && stop_a_reg) begin
                        k_next     = '0;
                        state_next = S_EMIT_RD;
                    end else begin
                        mx_raddr   = low_idx;
                        state_next = S_SEC_WAIT;
                    end
                end
            end
            S_SEC_WAIT: begin
                // every active victim of this victim loses one attacker
                pend_next = '0;
                for (int i = 0; i < NARG; i++) begin
                    if (second[i] && cnt_reg[i] != '0) begin
                        cnt_next[i]  = cnt_reg[i] - CW'(1);
                        pend_next[i] = (cnt_reg[i] == CW'(1));
                    end
                end
                enq_pop_next = 1'b0;
                state_next   = S_ENQ;
            end
            S_EMIT_RD: begin
                if (tail_reg == '0) begin
                    out_next.member    = '0;
                    out_next.is_last   = 1'b1;
                    out_next.contained = contained_reg;
                    out_next.attacked  = attacked_reg;
                    state_next         = S_EMIT_OUT;
                end else begin
                    q_raddr    = k_reg[IW-1:0];
                    state_next = S_EMIT_LD;
                end
            end
            S_EMIT_LD: begin
                out_next.member    = q_rdata;
                out_next.is_last   = (k_reg + QW'(1) == tail_reg);
                out_next.contained = (k_reg + QW'(1) == tail_reg) && contained_reg;
                out_next.attacked  = (k_reg + QW'(1) == tail_reg) && attacked_reg;
                k_next             = k_reg + QW'(1);
                state_next         = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (m_ready) begin
                    state_next = out_reg.is_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            arg_count_reg <= '0;
            stop_c_reg    <= 1'b0;
            stop_a_reg    <= 1'b0;
            row_valid_reg <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            arg_count_reg <= arg_count_next;
            stop_c_reg    <= stop_c_next;
            stop_a_reg    <= stop_a_next;
            row_valid_reg <= row_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            rd_valid_reg  <= row_valid_reg[mx_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        active_reg    <= active_next;
        cnt_reg       <= cnt_next;
        pend_reg      <= pend_next;
        vic_reg       <= vic_next;
        row_ua_reg    <= row_ua_next;
        ua_reg        <= ua_next;
        idx_reg       <= idx_next;
        bit_reg       <= bit_next;
        query_reg     <= query_next;
        k_reg         <= k_next;
        contained_reg <= contained_next;
        attacked_reg  <= attacked_next;
        enq_pop_reg   <= enq_pop_next;
        out_reg       <= out_next;
    end

    `GEE_ASSERT(a_head_le_tail, head_reg <= tail_reg, "queue head passed tail")
    `GEE_ASSERT(a_tail_bound, tail_reg <= QW'(MAX_ARGS), "queue holds too many arguments")
    `GEE_IMPLY(a_member_nonzero, m_valid && tail_reg != '0, m_data.member != '0, "zero member")
    `GEE_IMPLY(a_flags_last, m_valid && !m_data.is_last, !m_data.contained && !m_data.attacked, "early flags")

endmodule

// ===== sim/grounded_extension_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grounded_extension_engine_tb
// self-checking bench: graphs are loaded edge by edge and solved with run
// items; a local solver predicts every extension member and the query flags
// ----------------------------------------------------------------------------
module grounded_extension_engine_tb;
    import gee_pkg::*;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [1:0]       cfg_index = CFG_ARG_COUNT;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    gee_in_t          s_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    gee_out_t         m_data;

    grounded_extension_engine u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #4 aclk = ~aclk;

    // local copy of the graph and configuration
    logic [63:0] graph [64];
    logic [5:0]  arg_total;
    logic        halt_on_member;
    logic        halt_on_hit;

    gee_in_t  pending_items [$];
    gee_out_t members_due [$];
    int       fail_count = 0;
    int       runs_sent = 0;
    int       members_seen = 0;
    bit       calm = 1'b0;
    bit       in_fire = 1'b0;

    function automatic void solve_item(gee_in_t it);
        logic [63:0] alive;
        logic [6:0]  cnt [64];
        logic [5:0]  order [64];
        int          head, tail, n, total, w;
        bit          hit_in, hit_att, halted;
        logic [63:0] vic, sec;
        logic [5:0]  ua;
        gee_out_t    r;
        head = 0; tail = 0; hit_in = 0; hit_att = 0; halted = 0;
        case (gee_op_t'(it.opcode))
            OP_CLEAR: begin
                for (int i = 0; i < 64; i++) graph[i] = '0;
                return;
            end
            OP_ADD: begin
                graph[it.attacker][it.victim] = 1'b1;
                return;
            end
            OP_RUN: ;
            default: return;
        endcase
        n = arg_total;
        alive = '0;
        for (int v = 1; v <= n; v++) alive[v] = 1'b1;
        for (int v = 1; v <= n; v++) begin
            cnt[v] = '0;
            for (int a = 1; a <= n; a++) if (graph[a][v]) cnt[v]++;
            if (cnt[v] == 0) begin order[tail] = 6'(v); tail++; end
        end
        while (!halted && head < tail) begin
            ua = order[head];
            head++;
            if (it.query != 0 && ua == it.query) begin
                hit_in = 1;
                if (halt_on_member) break;
            end
            vic = graph[ua] & alive;
            for (int x = 0; x < 64 && !halted; x++) begin
                if (!vic[x]) continue;
                if (it.query != 0 && x == it.query) begin
                    hit_att = 1;
                    if (halt_on_hit) begin halted = 1; break; end
                end
                sec = graph[x] & alive;
                for (w = 0; w < 64; w++) begin
                    if (sec[w] && cnt[w] != 0) begin
                        cnt[w]--;
                        if (cnt[w] == 0 && tail < 64) begin order[tail] = 6'(w); tail++; end
                    end
                end
            end
            if (halted) break;
            alive &= ~((64'd1 << ua) | graph[ua]);
        end
        total = tail > 63 ? 63 : tail;
        if (total == 0) begin
            r = '{member: 6'd0, is_last: 1'b1, contained: hit_in, attacked: hit_att};
            members_due = {members_due, r};
        end
        for (int k = 0; k < total; k++) begin
            r.member = order[k];
            r.is_last = (k + 1 == total);
            r.contained = r.is_last & hit_in;
            r.attacked = r.is_last & hit_att;
            members_due = {members_due, r};
        end
    endfunction

    // driver: one transfer per accepted item, valid held until accepted
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_fire) begin
                if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 34)) begin
                    s_data <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= calm || ($urandom_range(99) >= 34);
        end
    end

    always @(posedge aclk) begin
        in_fire <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            if (s_data.opcode == OP_RUN) runs_sent++;
            solve_item(s_data);
        end
        if (aresetn && m_valid && m_ready) begin
            members_seen++;
            if (members_due.size() == 0) begin
                $error("unexpected result member=%0d", m_data.member);
                fail_count++;
            end else begin
                gee_out_t e;
                e = members_due.pop_front();
                if (e.member !== m_data.member) begin
                    $error("member exp %0d got %0d", e.member, m_data.member); fail_count++;
                end
                if (e.is_last !== m_data.is_last) begin
                    $error("is_last exp %0d got %0d", e.is_last, m_data.is_last); fail_count++;
                end
                if (e.contained !== m_data.contained) begin
                    $error("contained exp %0d got %0d", e.contained, m_data.contained);
                    fail_count++;
                end
                if (e.attacked !== m_data.attacked) begin
                    $error("attacked exp %0d got %0d", e.attacked, m_data.attacked);
                    fail_count++;
                end
            end
        end
    end

    function automatic gee_in_t make_item(gee_op_t op, int a, int v, int q);
        gee_in_t it;
        it.opcode = op;
        it.attacker = FIELD_W'(a);
        it.victim = FIELD_W'(v);
        it.query = FIELD_W'(q);
        return it;
    endfunction

    function automatic void queue_item(gee_in_t it);
        pending_items = {pending_items, it};
    endfunction

    task automatic drain_all();
        while (pending_items.size() != 0 || s_valid || members_due.size() != 0)
            @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_setup(int n, bit sc, bit sa);
        @(negedge aclk);
        cfg_wr_en <= 1'b1; cfg_index <= CFG_ARG_COUNT; cfg_wdata <= CFG_W'(n);
        @(negedge aclk);
        cfg_index <= CFG_STOP_CONT; cfg_wdata <= CFG_W'(sc);
        @(negedge aclk);
        cfg_index <= CFG_STOP_ATT; cfg_wdata <= CFG_W'(sa);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        arg_total = 6'(n); halt_on_member = sc; halt_on_hit = sa;
    endtask

    // random graph over arguments 1 to n with an occasional edge anywhere, then a few runs
    task automatic queue_random_graph(int n, int edges);
        queue_item(make_item(OP_CLEAR, $urandom, $urandom, $urandom));
        for (int i = 0; i < edges; i++) begin
            if ($urandom_range(9) == 0)
                queue_item(make_item(OP_ADD, $urandom_range(63), $urandom_range(63), 0));
            else
                queue_item(make_item(OP_ADD, $urandom_range(1, n), $urandom_range(1, n), 0));
        end
        if ($urandom_range(3) == 0)
            queue_item(make_item(OP_NOP, $urandom, $urandom, $urandom));
        for (int i = 0; i < 3; i++)
            queue_item(make_item(OP_RUN, $urandom, $urandom,
                $urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(n)));
    endtask

    initial begin
        int n;
        for (int i = 0; i < 64; i++) graph[i] = '0;
        arg_total = 0; halt_on_member = 0; halt_on_hit = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // directed: empty config, chain, self attack, extremes, early stops
        queue_item(make_item(OP_RUN, 0, 0, 0));
        drain_all();
        write_setup(5, 0, 0);
        queue_item(make_item(OP_ADD, 1, 2, 0));
        queue_item(make_item(OP_ADD, 2, 3, 0));
        queue_item(make_item(OP_ADD, 1, 2, 0));
        queue_item(make_item(OP_ADD, 4, 4, 0));
        queue_item(make_item(OP_ADD, 5, 63, 0));
        queue_item(make_item(OP_ADD, 0, 5, 0));
        queue_item(make_item(OP_RUN, 0, 0, 3));
        queue_item(make_item(OP_RUN, 63, 63, 2));
        queue_item(make_item(OP_RUN, 0, 0, 63));
        queue_item(make_item(OP_NOP, 63, 63, 63));
        drain_all();
        write_setup(5, 1, 1);
        queue_item(make_item(OP_RUN, 0, 0, 1));
        queue_item(make_item(OP_RUN, 0, 0, 2));
        queue_item(make_item(OP_CLEAR, 0, 0, 0));
        queue_item(make_item(OP_RUN, 0, 0, 4));
        drain_all();
        write_setup(63, 0, 0);
        queue_item(make_item(OP_ADD, 63, 62, 0));
        queue_item(make_item(OP_RUN, 0, 0, 62));
        drain_all();

        // random phases with varying setups; one phase never idles
        for (int p = 0; p < 14; p++) begin
            n = (p % 5 == 4) ? 63 : $urandom_range(2, 12);
            if (p == 13) n = 0;
            write_setup(n, $urandom_range(1), $urandom_range(1));
            calm = (p == 6);
            for (int g = 0; g < 2; g++) queue_random_graph(n == 0 ? 1 : n, 10);
            drain_all();
        end
        calm = 1'b0;
        write_setup(0, 0, 0);
        queue_item(make_item(OP_RUN, 0, 0, 0));
        drain_all();

        $display("ran %0d solver runs, checked %0d members", runs_sent, members_seen);
        $display("graph sizes 0 to 63 with early stop flags on and off");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
